// File: rtl/secap_pkg.sv
package secap_pkg;

  // field and datapath widths
  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W = 2 * COORD_W;
  localparam int R2_W = SQ_W + 1;
  localparam int CW = 28;
  localparam int ANG_W = 32;
  localparam int SWEEP_W = 16;
  localparam int AREA_W = 39;
  localparam int PERIM_W = 24;
  localparam int CHORD_W = 21;

  // square root chain: one result bit per cell
  localparam int SQRT_STAGES = 25;
  localparam int ROOT_W = SQRT_STAGES;
  localparam int SQRT_VAL_W = 2 * SQRT_STAGES;
  localparam int REM_W = ROOT_W + 3;

  // cordic chain
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int PRESCALE = 8;
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ROUND_HALF = 32'h0000_8000;

  // pi scaled for the area and arc products
  localparam int PI32_W = 34;
  localparam int PI20_W = 22;
  localparam logic [PI32_W-1:0] PI_Q32 = 34'd13493037705;
  localparam logic [PI20_W-1:0] PI_Q20 = 22'd3294199;

  // atan(2^-i) in turns, 2^32 is a full turn
  localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } item_t;

  typedef struct packed {
    logic [AREA_W-1:0]  area_q4;
    logic [PERIM_W-1:0] perimeter_q4;
    logic [SWEEP_W-1:0] sweep_turns;
    logic               zero_radius;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANG_W-1:0]     z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [SQRT_VAL_W-1:0] val;
    logic [ROOT_W-1:0]     root;
    logic [REM_W-1:0]      rem;
  } sqrt_t;

endpackage

// File: rtl/sector_area_and_perimeter_top.sv
// Sector area and perimeter from three points (center, arc start, arc end).
// One transaction is accepted per cycle while the output is not stalled, and each
// gives one result; the pipeline depth is set by the 25-cell square root chain
// that yields the radius, and the CORDIC_STAGES-cell vectoring chains for the
// two angles run beside it.
// A stall on the result side holds the whole pipeline.
module sector_area_and_perimeter_top #(
  parameter int CORDIC_STAGES = secap_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  secap_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output secap_pkg::result_t result
);
  import secap_pkg::*;

  localparam int LAT = SQRT_STAGES + 7;
  localparam int ANG_DELAY = SQRT_STAGES + 1 - CORDIC_STAGES;

  logic [LAT:1] vld;
  logic         en;

  // pipeline advance and valid tracking
  assign en = !(vld[LAT] && result_stall);
  assign item_stall = !en;
  assign result_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], item_valid};
    end
  end

  // vector differences
  logic signed [DIFF_W-1:0] dx, dy, qx, qy, hx, hy;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {item.start_x[COORD_W-1], item.start_x} - {item.center_x[COORD_W-1], item.center_x};
      dy <= {item.start_y[COORD_W-1], item.start_y} - {item.center_y[COORD_W-1], item.center_y};
      qx <= {item.end_x[COORD_W-1], item.end_x} - {item.center_x[COORD_W-1], item.center_x};
      qy <= {item.end_y[COORD_W-1], item.end_y} - {item.center_y[COORD_W-1], item.center_y};
      hx <= {item.end_x[COORD_W-1], item.end_x} - {item.start_x[COORD_W-1], item.start_x};
      hy <= {item.end_y[COORD_W-1], item.end_y} - {item.start_y[COORD_W-1], item.start_y};
    end
  end

  // squares and cordic set-up
  function automatic cordic_t cordic_pre(logic signed [DIFF_W-1:0] vx,
                                         logic signed [DIFF_W-1:0] vy);
    cordic_t              r;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    ex = CW'(vx);
    ey = CW'(vy);
    r.zero = (vx == '0) && (vy == '0);
    r.z = '0;
    if (vx < 0) begin
      ex = -ex;
      ey = -ey;
      r.z = HALF_TURN;
    end
    r.x = ex <<< PRESCALE;
    r.y = ey <<< PRESCALE;
    return r;
  endfunction

  logic signed [2*DIFF_W-1:0] p_dx, p_dy, p_hx, p_hy;
  logic [SQ_W-1:0]            sq_dx, sq_dy, sq_hx, sq_hy;
  cordic_t                    cs [CORDIC_STAGES+1];
  cordic_t                    ce [CORDIC_STAGES+1];

  always_comb begin
    p_dx = dx * dx;
    p_dy = dy * dy;
    p_hx = hx * hx;
    p_hy = hy * hy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_dx <= p_dx[SQ_W-1:0];
      sq_dy <= p_dy[SQ_W-1:0];
      sq_hx <= p_hx[SQ_W-1:0];
      sq_hy <= p_hy[SQ_W-1:0];
      cs[0] <= cordic_pre(dx, dy);
      ce[0] <= cordic_pre(qx, qy);
    end
  end

  // squared radius and squared chord
  logic [R2_W-1:0] r2, c2;

  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= {1'b0, sq_dx} + {1'b0, sq_dy};
      c2 <= {1'b0, sq_hx} + {1'b0, sq_hy};
    end
  end

  // cordic vectoring chains for the start and end directions
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    secap_cordic_cell #(.STAGE(i)) u_start (
      .clk (clk),
      .en  (en),
      .din (cs[i]),
      .dout(cs[i+1])
    );
    secap_cordic_cell #(.STAGE(i)) u_end (
      .clk (clk),
      .en  (en),
      .din (ce[i]),
      .dout(ce[i+1])
    );
  end

  logic [ANG_W-1:0] a0_in, a1_in, a0, a1;

  // a zero-length direction has angle zero
  assign a0_in = cs[CORDIC_STAGES].zero ? '0 : cs[CORDIC_STAGES].z;
  assign a1_in = ce[CORDIC_STAGES].zero ? '0 : ce[CORDIC_STAGES].z;

  secap_delay #(.W(ANG_W), .DEPTH(ANG_DELAY)) u_a0_dly (
    .clk (clk),
    .en  (en),
    .din (a0_in),
    .dout(a0)
  );

  secap_delay #(.W(ANG_W), .DEPTH(ANG_DELAY)) u_a1_dly (
    .clk (clk),
    .en  (en),
    .din (a1_in),
    .dout(a1)
  );

  // square root chains for radius and chord
  sqrt_t sr [SQRT_STAGES+1];
  sqrt_t sc [SQRT_STAGES+1];

  assign sr[0] = '{val: SQRT_VAL_W'({r2, 16'b0}), root: '0, rem: '0};
  assign sc[0] = '{val: SQRT_VAL_W'({c2, 8'b0}), root: '0, rem: '0};

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    secap_sqrt_cell u_rad (
      .clk (clk),
      .en  (en),
      .din (sr[k]),
      .dout(sr[k+1])
    );
    secap_sqrt_cell u_chord (
      .clk (clk),
      .en  (en),
      .din (sc[k]),
      .dout(sc[k+1])
    );
  end

  logic [R2_W-1:0] r2_d;

  secap_delay #(.W(R2_W), .DEPTH(SQRT_STAGES)) u_r2_dly (
    .clk (clk),
    .en  (en),
    .din (r2),
    .dout(r2_d)
  );

  // sweep with rounding to 16 bits of a turn
  logic [ANG_W-1:0]   diff_rnd;
  logic [SWEEP_W-1:0] sweep1, sweep2, sweep3;
  logic [R2_W-1:0]    r2_q;
  logic [ROOT_W-1:0]  rq8;
  logic [CHORD_W-1:0] chord1, chord2, chord3;
  logic               zr1, zr2, zr3;

  assign diff_rnd = a1 - a0 + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      sweep1 <= diff_rnd[ANG_W-1 -: SWEEP_W];
      r2_q <= r2_d;
      rq8 <= sr[SQRT_STAGES].root;
      chord1 <= sc[SQRT_STAGES].root[CHORD_W-1:0];
      zr1 <= (r2_d == '0);
    end
  end

  // first products
  localparam int P_W = R2_W + SWEEP_W;
  localparam int P_LO_W = 25;
  localparam int T_W = ROOT_W + SWEEP_W;
  logic [P_W-1:0] p;
  logic [T_W-1:0] t;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= r2_q * sweep1;
      t <= rq8 * sweep1;
      chord2 <= chord1;
      sweep2 <= sweep1;
      zr2 <= zr1;
    end
  end

  // products with pi, area split into high and low halves
  localparam int MHI_W = P_W - P_LO_W + PI32_W;
  localparam int MLO_W = P_LO_W + PI32_W;
  localparam int MARC_W = T_W + PI20_W;
  logic [MHI_W-1:0]  m_hi;
  logic [MLO_W-1:0]  m_lo;
  logic [MARC_W-1:0] m_arc;

  always_ff @(posedge clk) begin
    if (en) begin
      m_hi <= p[P_W-1:P_LO_W] * PI_Q32;
      m_lo <= p[P_LO_W-1:0] * PI_Q32;
      m_arc <= t * PI_Q20;
      chord3 <= chord2;
      sweep3 <= sweep2;
      zr3 <= zr2;
    end
  end

  // final sums and output register
  logic [MLO_W-1:0]   area_sum;
  logic [PERIM_W-1:0] arc;
  logic [PERIM_W:0]   perim;

  always_comb begin
    area_sum = MLO_W'(m_hi) + (m_lo >> P_LO_W);
    arc = m_arc[MARC_W-1 -: PERIM_W];
    perim = {1'b0, arc} + (PERIM_W+1)'(chord3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.area_q4 <= area_sum[19 +: AREA_W];
      result.perimeter_q4 <= perim[PERIM_W] ? '1 : perim[PERIM_W-1:0];
      result.sweep_turns <= sweep3;
      result.zero_radius <= zr3;
    end
  end

endmodule

// File: rtl/secap_cordic_cell.sv
module secap_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              en,
  input  secap_pkg::cordic_t din,
  output secap_pkg::cordic_t dout
);
  import secap_pkg::*;

  cordic_t              dout_next;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  // one vectoring micro-rotation towards the x axis
  always_comb begin
    xs = din.x >>> STAGE;
    ys = din.y >>> STAGE;
    dout_next.zero = din.zero;
    if (!din.y[CW-1]) begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + ATAN_TURNS[STAGE];
    end else begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - ATAN_TURNS[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// File: rtl/secap_sqrt_cell.sv
module secap_sqrt_cell (
  input  logic             clk,
  input  logic             en,
  input  secap_pkg::sqrt_t din,
  output secap_pkg::sqrt_t dout
);
  import secap_pkg::*;

  sqrt_t            dout_next;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  // one restoring step: bring down two bits, try the next root bit
  always_comb begin
    rem_sh = {din.rem[REM_W-3:0], din.val[SQRT_VAL_W-1 -: 2]};
    trial = {1'b0, din.root, 2'b01};
    dout_next.val = {din.val[SQRT_VAL_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      dout_next.rem = rem_sh - trial;
      dout_next.root = {din.root[ROOT_W-2:0], 1'b1};
    end else begin
      dout_next.rem = rem_sh;
      dout_next.root = {din.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// File: rtl/secap_delay.sv
module secap_delay #(
  parameter int W = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [DEPTH];

  // shift line that moves with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
